// File: design/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, codes and constants of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int ID_W       = 8;
  localparam int TIME_W     = 32;
  localparam int SVC_W      = 16;
  localparam int SLICE_W    = 8;
  localparam int STATUS_W   = 3;
  localparam int LVL_OUT_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int DEF_LEVELS    = 6;
  localparam int DEF_MAX_PROCS = 16;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;
  localparam logic [SLICE_W-1:0] IDLE_RESET  = 8'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADMITTED    = 3'd0,
    ST_FULL        = 3'd1,
    ST_OUT_OF_ORD  = 3'd2,
    ST_RAN         = 3'd3,
    ST_IDLE_REPORT = 3'd4,
    ST_IDLE_SILENT = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_SLICE   = 2'd0,
    CFG_IDLE_ADVANCE = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    OP_ADMIT = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN_RD,
    S_DRAIN_CMP,
    S_SCAN,
    S_SERVE,
    S_ADV,
    S_EMIT
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

endpackage

// File: design/mlfq_in_if.sv
// ----------------------------------------------------------------------------
// mlfq_in_if
// Input channel: admit or step request with process payload.
// ----------------------------------------------------------------------------
interface mlfq_in_if import mlfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ID_W-1:0]   process_id;
  logic [TIME_W-1:0] arrival_time;
  logic [SVC_W-1:0]  service_time;

  modport source (output valid, op, process_id, arrival_time, service_time, input ready);
  modport sink   (input valid, op, process_id, arrival_time, service_time, output ready);
endinterface

// File: design/mlfq_out_if.sv
// ----------------------------------------------------------------------------
// mlfq_out_if
// Result channel: one result transaction per input transaction.
// ----------------------------------------------------------------------------
interface mlfq_out_if import mlfq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      ran_id;
  logic [LVL_OUT_W-1:0] ran_level;
  logic [SLICE_W-1:0]   slice_used;
  logic                 finished;
  logic [TIME_W-1:0]    clock_now;

  modport source (output valid, status, ran_id, ran_level, slice_used, finished, clock_now,
                  input ready);
  modport sink   (input valid, status, ran_id, ran_level, slice_used, finished, clock_now,
                  output ready);
endinterface

// File: design/mlfq_cfg_if.sv
// ----------------------------------------------------------------------------
// mlfq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mlfq_cfg_if import mlfq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/mlfq_alu.sv
// ----------------------------------------------------------------------------
// mlfq_alu
// Shared add/subtract unit; subtract also yields an unsigned less-than flag.
// ----------------------------------------------------------------------------
module mlfq_alu import mlfq_pkg::*; (
  input  alu_req_t          req_i,
  output logic [TIME_W-1:0] res_o,
  output logic              lt_o
);

  logic              sub;
  logic [TIME_W-1:0] b_eff;
  logic [TIME_W:0]   sum;

  assign sub   = (req_i.op == ALU_SUB);
  assign b_eff = sub ? ~req_i.b : req_i.b;
  assign sum   = {1'b0, req_i.a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, sub};
  assign res_o = sum[TIME_W-1:0];
  // borrow out of a - b
  assign lt_o  = sub & ~sum[TIME_W];

endmodule

// File: design/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/multilevel_feedback_scheduler_top.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_top
// Multilevel feedback queue scheduler: pending FIFO feeding LEVELS queue levels.
// Admit: S_IDLE accepts, then S_EMIT loads the result into the output register.
// Step: S_DRAIN_RD and S_DRAIN_CMP move due processes from the pending FIFO to
// level 0, S_SCAN picks a level, S_SERVE serves its head if one is queued, S_ADV
// advances the clock and S_EMIT loads the result; the RAM reads are registered.
// One transaction at a time; the result register frees the input side.
// Reset: asynchronous, clears queues, counters, clock and result valid; no sweep.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_top import mlfq_pkg::*; #(
  parameter int LEVELS    = DEF_LEVELS,
  parameter int MAX_PROCS = DEF_MAX_PROCS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlfq_in_if.sink    in_i,
  mlfq_out_if.source out_o,
  mlfq_cfg_if.sink   cfg_i
);

  localparam int LW    = $clog2(LEVELS);
  localparam int PW    = $clog2(MAX_PROCS);
  localparam int CW    = $clog2(MAX_PROCS + 1);
  localparam int LAW   = LW + PW;
  localparam int LDEP  = LEVELS << PW;
  localparam int LDW   = ID_W + SVC_W;
  localparam int PDW   = ID_W + TIME_W + SVC_W;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] h, logic [CW-1:0] c);
    logic [PW:0] s;
    s = {1'b0, h} + (PW+1)'(c);
    if (s >= (PW+1)'(MAX_PROCS)) s = s - (PW+1)'(MAX_PROCS);
    return s[PW-1:0];
  endfunction

  // control state
  state_e             state_q, state_d;
  logic [TIME_W-1:0]  clock_q, clock_d;
  logic [TIME_W-1:0]  last_arr_q, last_arr_d;
  logic               prev_idle_q, prev_idle_d;
  logic [PW-1:0]      pend_head_q, pend_head_d;
  logic [CW-1:0]      pend_cnt_q, pend_cnt_d;
  logic [CW-1:0]      live_cnt_q, live_cnt_d;
  logic [PW-1:0]      lvl_head_q [LEVELS];
  logic [PW-1:0]      lvl_head_d [LEVELS];
  logic [CW-1:0]      lvl_cnt_q [LEVELS];
  logic [CW-1:0]      lvl_cnt_d [LEVELS];
  logic [SLICE_W-1:0] slice_q, idle_adv_q;
  logic               out_valid_q, out_valid_d;

  // result payload under construction
  status_e            res_status_q, res_status_d;
  logic [ID_W-1:0]    res_id_q, res_id_d;
  logic [LW-1:0]      res_lvl_q, res_lvl_d;
  logic [SLICE_W-1:0] res_used_q, res_used_d;
  logic               res_fin_q, res_fin_d;
  logic [SLICE_W-1:0] adv_q, adv_d;

  // output register
  status_e            out_status_q;
  logic [ID_W-1:0]    out_id_q;
  logic [LW-1:0]      out_lvl_q;
  logic [SLICE_W-1:0] out_used_q;
  logic               out_fin_q;
  logic [TIME_W-1:0]  out_clock_q;
  logic               out_load;

  // shared unit
  alu_req_t           alu_req;
  logic [TIME_W-1:0]  alu_res;
  logic               alu_lt;

  // memories
  logic               pend_we;
  logic [PW-1:0]      pend_waddr;
  logic [PDW-1:0]     pend_wdata, pend_rdata;
  logic [ID_W-1:0]    pend_id;
  logic [TIME_W-1:0]  pend_arr;
  logic [SVC_W-1:0]   pend_svc;
  logic               lvl_we;
  logic [LAW-1:0]     lvl_waddr, lvl_raddr;
  logic [LDW-1:0]     lvl_wdata, lvl_rdata;
  logic [ID_W-1:0]    lvl_id;
  logic [SVC_W-1:0]   lvl_rem;

  // level selection
  logic               found_any;
  logic [LW-1:0]      found_lv, next_lv;
  logic               in_acc, full, fin;

  assign in_acc   = in_i.valid & in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign {pend_id, pend_arr, pend_svc} = pend_rdata;
  assign {lvl_id, lvl_rem}             = lvl_rdata;

  // lowest-numbered non-empty level
  always_comb begin
    found_any = 1'b0;
    found_lv  = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (lvl_cnt_q[i] != '0) begin
        found_any = 1'b1;
        found_lv  = LW'(i);
      end
    end
  end

  assign next_lv   = (found_lv == LW'(LEVELS - 1)) ? found_lv : found_lv + LW'(1);
  assign lvl_raddr = {found_lv, lvl_head_q[found_lv]};
  assign full      = (live_cnt_q >= CW'(MAX_PROCS));
  assign fin       = alu_lt | (alu_res == '0);

  mlfq_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  mlfq_ram #(
    .WIDTH (PDW),
    .DEPTH (MAX_PROCS),
    .AW    (PW)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (pend_head_q),
    .rdata_o (pend_rdata)
  );

  mlfq_ram #(
    .WIDTH (LDW),
    .DEPTH (LDEP),
    .AW    (LAW)
  ) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  // shared unit operand select
  always_comb begin
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    unique case (state_q)
      S_IDLE:      alu_req = '{op: ALU_SUB, a: in_i.arrival_time, b: last_arr_q};
      S_DRAIN_CMP: alu_req = '{op: ALU_SUB, a: clock_q, b: pend_arr};
      S_SERVE:     alu_req = '{op: ALU_SUB, a: TIME_W'(lvl_rem), b: TIME_W'(slice_q)};
      S_ADV:       alu_req = '{op: ALU_ADD, a: clock_q, b: TIME_W'(adv_q)};
      default:     alu_req = '{op: ALU_ADD, a: '0, b: '0};
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    clock_d      = clock_q;
    last_arr_d   = last_arr_q;
    prev_idle_d  = prev_idle_q;
    pend_head_d  = pend_head_q;
    pend_cnt_d   = pend_cnt_q;
    live_cnt_d   = live_cnt_q;
    lvl_head_d   = lvl_head_q;
    lvl_cnt_d    = lvl_cnt_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_lvl_d    = res_lvl_q;
    res_used_d   = res_used_q;
    res_fin_d    = res_fin_q;
    adv_d        = adv_q;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q & ~out_o.ready;
    pend_we      = 1'b0;
    pend_waddr   = wrap_add(pend_head_q, pend_cnt_q);
    pend_wdata   = {in_i.process_id, in_i.arrival_time, in_i.service_time};
    lvl_we       = 1'b0;
    lvl_waddr    = {next_lv, wrap_add(lvl_head_q[next_lv], lvl_cnt_q[next_lv])};
    lvl_wdata    = {lvl_id, alu_res[SVC_W-1:0]};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_id_d   = '0;
          res_lvl_d  = '0;
          res_used_d = '0;
          res_fin_d  = 1'b0;
          if (in_i.op == OP_STEP) begin
            state_d = S_DRAIN_RD;
          end else begin
            state_d = S_EMIT;
            if (full) begin
              res_status_d = ST_FULL;
            end else if (alu_lt) begin
              res_status_d = ST_OUT_OF_ORD;
            end else begin
              res_status_d = ST_ADMITTED;
              pend_we      = 1'b1;
              pend_cnt_d   = pend_cnt_q + CW'(1);
              live_cnt_d   = live_cnt_q + CW'(1);
              last_arr_d   = in_i.arrival_time;
            end
          end
        end
      end

      // RAM read of the pending head lands next cycle
      S_DRAIN_RD: begin
        state_d = (pend_cnt_q == '0) ? S_SCAN : S_DRAIN_CMP;
      end

      S_DRAIN_CMP: begin
        if (alu_lt) begin
          state_d = S_SCAN;
        end else begin
          state_d      = S_DRAIN_RD;
          lvl_we       = 1'b1;
          lvl_waddr    = {LW'(0), wrap_add(lvl_head_q[0], lvl_cnt_q[0])};
          lvl_wdata    = {pend_id, pend_svc};
          lvl_cnt_d[0] = lvl_cnt_q[0] + CW'(1);
          pend_head_d  = wrap_add(pend_head_q, CW'(1));
          pend_cnt_d   = pend_cnt_q - CW'(1);
        end
      end

      S_SCAN: begin
        if (found_any) begin
          state_d = S_SERVE;
        end else begin
          state_d      = S_ADV;
          res_status_d = prev_idle_q ? ST_IDLE_REPORT : ST_IDLE_SILENT;
          prev_idle_d  = 1'b1;
          adv_d        = idle_adv_q;
        end
      end

      // a - b = rem - slice: borrow or zero means the process is done
      S_SERVE: begin
        state_d      = S_ADV;
        prev_idle_d  = 1'b0;
        res_status_d = ST_RAN;
        res_id_d     = lvl_id;
        res_lvl_d    = found_lv;
        res_used_d   = alu_lt ? lvl_rem[SLICE_W-1:0] : slice_q;
        res_fin_d    = fin;
        adv_d        = alu_lt ? lvl_rem[SLICE_W-1:0] : slice_q;
        lvl_head_d[found_lv] = wrap_add(lvl_head_q[found_lv], CW'(1));
        lvl_cnt_d[found_lv]  = lvl_cnt_q[found_lv] - CW'(1);
        if (fin) begin
          if (live_cnt_q != '0) live_cnt_d = live_cnt_q - CW'(1);
        end else begin
          lvl_we             = 1'b1;
          lvl_cnt_d[next_lv] = lvl_cnt_d[next_lv] + CW'(1);
        end
      end

      S_ADV: begin
        state_d = S_EMIT;
        clock_d = alu_res;
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clock_q     <= '0;
      last_arr_q  <= '0;
      prev_idle_q <= 1'b1;
      pend_head_q <= '0;
      pend_cnt_q  <= '0;
      live_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        lvl_head_q[i] <= '0;
        lvl_cnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      clock_q     <= clock_d;
      last_arr_q  <= last_arr_d;
      prev_idle_q <= prev_idle_d;
      pend_head_q <= pend_head_d;
      pend_cnt_q  <= pend_cnt_d;
      live_cnt_q  <= live_cnt_d;
      out_valid_q <= out_valid_d;
      lvl_head_q  <= lvl_head_d;
      lvl_cnt_q   <= lvl_cnt_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q    <= SLICE_RESET;
      idle_adv_q <= IDLE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_TIME_SLICE:   slice_q    <= cfg_i.data;
        CFG_IDLE_ADVANCE: idle_adv_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_lvl_q    <= res_lvl_d;
    res_used_q   <= res_used_d;
    res_fin_q    <= res_fin_d;
    adv_q        <= adv_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_lvl_q    <= res_lvl_q;
      out_used_q   <= res_used_q;
      out_fin_q    <= res_fin_q;
      out_clock_q  <= clock_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.ran_id     = out_id_q;
  assign out_o.ran_level  = LVL_OUT_W'(out_lvl_q);
  assign out_o.slice_used = out_used_q;
  assign out_o.finished   = out_fin_q;
  assign out_o.clock_now  = out_clock_q;

endmodule
